// ===== sv/uitf_pkg.sv =====
// ----------------------------------------------------------------------------
// uitf_pkg
// Shared types and constants for the UART idle-timeout frame receiver.
// ----------------------------------------------------------------------------
package uitf_pkg;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int LIMIT_W  = 16;

    localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 16'd50;
    localparam logic [LIMIT_W-1:0] IDLE_SAT         = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_POLL  = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

endpackage

// ===== sv/uitf_req_if.sv =====
// ----------------------------------------------------------------------------
// uitf_req_if
// Command channel: valid/ready handshake carrying one command transaction.
// ----------------------------------------------------------------------------
interface uitf_req_if
    import uitf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] read_index;

    modport source (output valid, output cmd, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input cmd, input rx_byte, input read_index,
                    output ready);
endinterface

// ===== sv/uitf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// uitf_rsp_if
// Result channel: valid/ready handshake carrying one status transaction.
// ----------------------------------------------------------------------------
interface uitf_rsp_if
    import uitf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic              receiving;

    modport source (output valid, output frame_ready, output frame_length,
                    output read_data, output read_valid, output receiving,
                    input ready);
    modport sink   (input valid, input frame_ready, input frame_length,
                    input read_data, input read_valid, input receiving,
                    output ready);
endinterface

// ===== sv/uitf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// uitf_cfg_if
// Configuration write channel for the idle limit register.
// ----------------------------------------------------------------------------
interface uitf_cfg_if
    import uitf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/uitf_frame_mem.sv =====
// ----------------------------------------------------------------------------
// uitf_frame_mem
// Two-bank byte store: one bank collects received bytes, the other holds
// the last completed frame. Banks swap on frame end.
// ----------------------------------------------------------------------------
module uitf_frame_mem
    import uitf_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     wr_bank,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [BYTE_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic                     rd_bank,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [BYTE_W-1:0]        rd_data
);

    localparam int IW = $clog2(DEPTH);

    // each bank spans the full index range so {bank, idx} stays in bounds
    logic [BYTE_W-1:0] mem [2**(IW+1)];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_bank, wr_idx}] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_bank, rd_idx}];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/uart_idle_timeout_framer.sv =====
// ----------------------------------------------------------------------------
// uart_idle_timeout_framer
// Collects received bytes and closes a frame after idle_limit idle ticks.
// An accepted command enters the input register and its result then moves to
// the result register once that register is free.
// Throughput: one command per cycle; each command needs at most one store
// access. Input stalls only while a held result waits on the output.
// Frame end swaps the two store banks, so no copy cycles are spent.
// Reset clears framer state and stage valid bits, loads idle_limit with 50;
// the byte store needs no clearing pass and commands are taken right away.
// ----------------------------------------------------------------------------
module uart_idle_timeout_framer
    import uitf_pkg::*;
#(
    parameter int BUF_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    uitf_req_if.sink   req,
    uitf_rsp_if.source rsp,
    uitf_cfg_if.sink   cfg
);

    localparam int IW   = $clog2(BUF_DEPTH);
    localparam int CW   = $clog2(BUF_DEPTH + 1);
    localparam int CMPW = (CW > BYTE_W) ? CW : BYTE_W;
    localparam logic [CW-1:0]   DEPTH_CNT = CW'(BUF_DEPTH);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(BUF_DEPTH);

    // input stage
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [BYTE_W-1:0] s1_idx_reg;

    // result stage
    logic              s2_valid_reg;
    logic              s2_frame_ready_reg;
    logic [LEN_W-1:0]  s2_frame_length_reg;
    logic              s2_read_valid_reg;
    logic              s2_receiving_reg;

    // framer state
    logic [LIMIT_W-1:0] idle_limit_reg;
    logic [CW-1:0]      wr_idx_reg, wr_idx_next;
    logic [CW-1:0]      seen_reg, seen_next;
    logic [LIMIT_W-1:0] idle_reg, idle_next;
    logic               active_reg, active_next;
    logic               ready_flag_reg, ready_flag_next;
    logic [CW-1:0]      latched_reg, latched_next;
    logic               bank_reg, bank_next;

    logic               s2_free;
    logic               s1_adv;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic               frame_end;
    logic               frame_ready_next;
    logic               read_valid_next;
    logic [LIMIT_W-1:0] idle_inc;
    logic [CMPW-1:0]    idx_cmp;
    logic [CMPW-1:0]    latched_cmp;
    logic [BYTE_W-1:0]  mem_rd_data;

    assign s2_free   = !s2_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign req.ready = !s1_valid_reg || s2_free;
    assign cfg.ready = 1'b1;

    assign idle_inc    = (idle_reg == IDLE_SAT) ? idle_reg : idle_reg + 1'b1;
    assign idx_cmp     = CMPW'(s1_idx_reg);
    assign latched_cmp = CMPW'(latched_reg);

    always_comb
    begin
        wr_idx_next      = wr_idx_reg;
        seen_next        = seen_reg;
        idle_next        = idle_reg;
        active_next      = active_reg;
        ready_flag_next  = ready_flag_reg;
        latched_next     = latched_reg;
        bank_next        = bank_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        frame_end        = 1'b0;
        frame_ready_next = 1'b0;
        read_valid_next  = 1'b0;

        if (s1_adv)
        begin
            unique case (cmd_t'(s1_cmd_reg))
                CMD_BYTE:
                begin
                    active_next = 1'b1;
                    if (wr_idx_reg < DEPTH_CNT)
                    begin
                        mem_wr_en   = 1'b1;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                    else
                    begin
                        // store full: drop the byte and wrap
                        wr_idx_next = '0;
                    end
                end
                CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        if (seen_reg < wr_idx_reg)
                        begin
                            seen_next = wr_idx_reg;
                            idle_next = '0;
                        end
                        else
                        begin
                            idle_next = idle_inc;
                            if (idle_inc >= idle_limit_reg)
                            begin
                                // close the frame: hand the collecting bank over
                                frame_end       = 1'b1;
                                latched_next    = seen_reg;
                                ready_flag_next = 1'b1;
                                bank_next       = !bank_reg;
                                wr_idx_next     = '0;
                                seen_next       = '0;
                                idle_next       = '0;
                                active_next     = 1'b0;
                            end
                        end
                    end
                end
                CMD_POLL:
                begin
                    frame_ready_next = ready_flag_reg;
                    ready_flag_next  = 1'b0;
                end
                CMD_READ:
                begin
                    if (idx_cmp < latched_cmp && idx_cmp < DEPTH_CMP)
                    begin
                        mem_rd_en       = 1'b1;
                        read_valid_next = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    ready_flag_next = 1'b0;
                    latched_next    = '0;
                    wr_idx_next     = '0;
                    seen_next       = '0;
                    idle_next       = '0;
                    active_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            idle_limit_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg     <= '0;
            seen_reg       <= '0;
            idle_reg       <= '0;
            active_reg     <= 1'b0;
            ready_flag_reg <= 1'b0;
            latched_reg    <= '0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            wr_idx_reg     <= wr_idx_next;
            seen_reg       <= seen_next;
            idle_reg       <= idle_next;
            active_reg     <= active_next;
            ready_flag_reg <= ready_flag_next;
            latched_reg    <= latched_next;
            bank_reg       <= bank_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_byte_reg <= req.rx_byte;
            s1_idx_reg  <= req.read_index;
        end
        if (s1_adv)
        begin
            s2_frame_ready_reg  <= frame_ready_next;
            s2_frame_length_reg <= LEN_W'(latched_next);
            s2_read_valid_reg   <= read_valid_next;
            s2_receiving_reg    <= active_next;
        end
    end

    uitf_frame_mem #(
        .DEPTH (BUF_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_bank (bank_reg),
        .wr_idx  (wr_idx_reg[IW-1:0]),
        .wr_data (s1_byte_reg),
        .rd_en   (mem_rd_en),
        .rd_bank (!bank_reg),
        .rd_idx  (IW'(s1_idx_reg)),
        .rd_data (mem_rd_data)
    );

    assign rsp.valid        = s2_valid_reg;
    assign rsp.frame_ready  = s2_frame_ready_reg;
    assign rsp.frame_length = s2_frame_length_reg;
    assign rsp.read_data    = s2_read_valid_reg ? mem_rd_data : '0;
    assign rsp.read_valid   = s2_read_valid_reg;
    assign rsp.receiving    = s2_receiving_reg;

    // write index never runs past the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= DEPTH_CNT)
        else $error("write index beyond store depth");

    // an idle collector holds no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (wr_idx_reg == '0 && seen_reg == '0 && idle_reg == '0))
        else $error("collector counters set while inactive");

    // frame end raises the ready flag and swaps banks
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (ready_flag_reg && bank_reg != $past(bank_reg)))
        else $error("frame end did not publish the frame");

    // banks only swap on frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        !frame_end |=> $stable(bank_reg))
        else $error("bank swapped without frame end");

    // reads only hit the completed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (idx_cmp < latched_cmp))
        else $error("read beyond latched frame length");

endmodule
